// File: hw/rtl/irfm_pkg.sv
// ----------------------------------------------------------------------------
// irfm_pkg
// Shared constants, types and codes of the forward-mapped image rotator.
// ----------------------------------------------------------------------------
package irfm_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIXEL_BITS  = 8;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W       = COL_W + 1;        // holds MAX_WIDTH itself
  localparam int ADDR_W      = COL_W + ROW_W;    // row-major, row above column
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int COEF_W      = 20;               // Q4.16
  localparam int FRAC_W      = 16;
  localparam int CTR_W       = 8;                // center_x / center_y
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;

  localparam int DELTA_W     = CTR_W + 1;        // signed offset from center
  localparam int PROD_W      = COEF_W + DELTA_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int COORD_W     = 16;               // signed mapped coordinate

  localparam logic signed [COEF_W-1:0] ALPHA_RESET = COEF_W'(65536);
  localparam logic [DIM_W-1:0]         WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]         HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA    = 3'd0,
    REG_BETA     = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_FILL     = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_EXEC,
    S_MAP,
    S_READ
  } state_t;

  // Mapped target of one source pixel.
  typedef struct packed {
    logic             hit;   // target lies inside the frame
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } map_res_t;

endpackage

// File: hw/rtl/irfm_store.sv
// ----------------------------------------------------------------------------
// irfm_store
// Frame store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module irfm_store (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [irfm_pkg::ADDR_W-1:0]            waddr,
  input  logic [irfm_pkg::PIXEL_BITS-1:0]        wdata,
  input  logic [irfm_pkg::ADDR_W-1:0]            raddr0,
  input  logic [irfm_pkg::ADDR_W-1:0]            raddr1,
  output logic [irfm_pkg::PIXEL_BITS-1:0]        rdata0,
  output logic [irfm_pkg::PIXEL_BITS-1:0]        rdata1
);
  import irfm_pkg::*;

  logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: hw/rtl/irfm_map.sv
// ----------------------------------------------------------------------------
// irfm_map
// Coordinate mapper: four products through one shared multiplier, then
// half-away-from-zero rounding, recentering and a frame bounds check.
// ----------------------------------------------------------------------------
module irfm_map (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic [irfm_pkg::COL_W-1:0]             col,
  input  logic [irfm_pkg::ROW_W-1:0]             row,
  input  logic signed [irfm_pkg::COEF_W-1:0]     alpha,
  input  logic signed [irfm_pkg::COEF_W-1:0]     beta,
  input  logic [irfm_pkg::CTR_W-1:0]             center_x,
  input  logic [irfm_pkg::CTR_W-1:0]             center_y,
  input  logic [irfm_pkg::DIM_W-1:0]             width,
  input  logic [irfm_pkg::DIM_W-1:0]             height,
  output logic                                   done,
  output irfm_pkg::map_res_t                     res
);
  import irfm_pkg::*;

  localparam int RND_W = SUM_W - FRAC_W;

  logic [2:0]                step;
  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [DELTA_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   acc;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [COORD_W-1:0] nx, ny;

  function automatic logic signed [COORD_W-1:0] round_q16(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] r;
    logic [RND_W-1:0] q;
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    r   = mag + SUM_W'(1 << (FRAC_W - 1));
    q   = r[SUM_W-1:FRAC_W];
    return s[SUM_W-1] ? -COORD_W'(q) : COORD_W'(q);
  endfunction

  assign dx = DELTA_W'({1'b0, col}) - DELTA_W'({1'b0, center_x});
  assign dy = DELTA_W'({1'b0, row}) - DELTA_W'({1'b0, center_y});

  // step 0: a*dx, 1: b*dy, 2: a*dy, 3: b*dx
  always_comb begin
    unique case (step)
      3'd1:    begin mul_a = beta;  mul_b = dy; end
      3'd2:    begin mul_a = alpha; mul_b = dy; end
      3'd3:    begin mul_a = beta;  mul_b = dx; end
      default: begin mul_a = alpha; mul_b = dx; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (step)
      3'd1:    acc   <= SUM_W'(prod);
      3'd2:    sum_x <= acc + SUM_W'(prod);
      3'd3:    acc   <= SUM_W'(prod);
      3'd4:    acc   <= acc - SUM_W'(prod);
      default: ;
    endcase
  end

  assign nx = round_q16(sum_x) + COORD_W'({1'b0, center_x});
  assign ny = round_q16(acc)   + COORD_W'({1'b0, center_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (step == 3'd0) begin
        if (go) begin
          step <= 3'd1;
        end
      end else if (step == 3'd5) begin
        step <= 3'd0;
        done <= 1'b1;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step == 3'd5) begin
      res.hit <= !nx[COORD_W-1] && (nx < COORD_W'(width)) &&
                 !ny[COORD_W-1] && (ny < COORD_W'(height));
      res.col <= nx[COL_W-1:0];
      res.row <= ny[ROW_W-1:0];
    end
  end

endmodule

// File: hw/rtl/image_rotate_forward_map.sv
// ----------------------------------------------------------------------------
// image_rotate_forward_map
// Nearest-neighbor forward-mapped image rotation with a hole-filling readout.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                    Transfer
//  -------   -----------------------------------------  ---------------------
//  command   start, busy, cmd, pixel_in                 start & !busy
//  result    done, pixel_out, last_of_frame             done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
//  A load (cmd=0) passes through the accept cycle, a dispatch cycle, five
//  mapper steps (four products through one multiplier, then rounding and
//  bounds check) and the mapper's done cycle, which carries the store write.
//  A read (cmd=1) fetches the pixel and its right neighbor from the
//  store's two read ports; the result strobe follows the read.
//  The first command of a frame first sweeps every store entry to the
//  fill value, one entry per cycle; busy stays high throughout.
//  Reset (rst, synchronous) clears all counters and the phase; store
//  contents are left as they are since every frame starts with the sweep.
//  The receiver cannot stall; the result strobe is a single-cycle pulse.
//
module image_rotate_forward_map (
  input  logic                                   clk,
  input  logic                                   rst,
  // command transaction
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cmd,
  input  logic [irfm_pkg::PIXEL_BITS-1:0]        pixel_in,
  // result transaction
  output logic                                   done,
  output logic [irfm_pkg::PIXEL_BITS-1:0]        pixel_out,
  output logic                                   last_of_frame,
  // config write transaction
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [irfm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [irfm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import irfm_pkg::*;

  // config registers
  logic signed [COEF_W-1:0] alpha, beta;
  logic [CTR_W-1:0]         center_x, center_y;
  logic [PIXEL_BITS-1:0]    fill_value;
  logic [DIM_W-1:0]         image_width, image_height;

  // frame control
  state_t                   state, state_next;
  logic                     cmd_q;
  logic [PIXEL_BITS-1:0]    pix_q;
  logic [COL_W-1:0]         load_col;
  logic [ROW_W:0]           load_row;      // reaches height at frame end
  logic [COL_W-1:0]         read_col;
  logic [ROW_W-1:0]         read_row;
  logic                     readout_phase;
  logic [PIXEL_BITS-1:0]    filled_left;
  logic [ADDR_W-1:0]        clr_addr;

  // effective frame size, clamped to [1, MAX]
  logic [DIM_W-1:0]         w_cur, h_cur;

  // store and mapper hookup
  logic                     st_we;
  logic [ADDR_W-1:0]        st_waddr;
  logic [PIXEL_BITS-1:0]    st_wdata;
  logic [ADDR_W-1:0]        st_raddr0, st_raddr1;
  logic [PIXEL_BITS-1:0]    st_rdata0, st_rdata1;
  logic                     map_go;
  logic                     map_done;
  map_res_t                 map_res;

  logic                     accept;
  logic                     frame_new;
  logic                     load_oob, read_oob;
  logic [DIM_W-1:0]         col_inc;
  logic [ROW_W:0]           row_inc;
  logic [DIM_W-1:0]         rcol_inc;
  logic [DIM_W-1:0]         rrow_inc;
  logic                     inner, hole;
  logic [PIXEL_BITS:0]      nb_sum;
  logic [PIXEL_BITS-1:0]    rd_val;
  logic                     rd_last;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    w_cur = image_width;
    if (image_width == '0) begin
      w_cur = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_cur = DIM_W'(MAX_WIDTH);
    end
    h_cur = image_height;
    if (image_height == '0) begin
      h_cur = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_cur = DIM_W'(MAX_HEIGHT);
    end
  end

  // a frame starts with the first command while loading at position zero
  assign frame_new = !readout_phase && (load_col == '0) && (load_row == '0);
  assign load_oob  = ({1'b0, load_col} >= w_cur) || (load_row >= (ROW_W+1)'(h_cur));
  assign read_oob  = ({1'b0, read_col} >= w_cur) || ({1'b0, read_row} >= h_cur);
  assign col_inc   = {1'b0, load_col} + DIM_W'(1);
  assign row_inc   = load_row + (ROW_W+1)'(1);
  assign rcol_inc  = {1'b0, read_col} + DIM_W'(1);
  assign rrow_inc  = {1'b0, read_row} + DIM_W'(1);

  // hole fill: inner column, stored zero, left neighbor already nonzero
  assign inner   = (read_col != '0) && (rcol_inc < w_cur);
  assign hole    = inner && (st_rdata0 == '0) && (filled_left != '0);
  assign nb_sum  = {1'b0, filled_left} + {1'b0, st_rdata1};
  assign rd_val  = hole ? nb_sum[PIXEL_BITS:1] : st_rdata0;
  assign rd_last = (rcol_inc == w_cur) && (rrow_inc == h_cur);

  // ---------------- config register file ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= ALPHA_RESET;
      beta         <= '0;
      center_x     <= '0;
      center_y     <= '0;
      fill_value   <= '0;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA:    alpha        <= cfg_data[COEF_W-1:0];
        REG_BETA:     beta         <= cfg_data[COEF_W-1:0];
        REG_CENTER_X: center_x     <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y: center_y     <= cfg_data[CTR_W-1:0];
        REG_FILL:     fill_value   <= cfg_data[PIXEL_BITS-1:0];
        REG_WIDTH:    image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   image_height <= cfg_data[DIM_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!cmd && readout_phase) begin
            state_next = S_IDLE;          // load after loading ended: ignored
          end else if (frame_new) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q) begin
          state_next = read_oob ? S_IDLE : S_READ;
        end else begin
          state_next = load_oob ? S_IDLE : S_MAP;
        end
      end
      S_MAP: begin
        if (map_done) begin
          state_next = S_IDLE;
        end
      end
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- sequencer: store and mapper controls ----------------
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_addr;
    st_wdata = fill_value;
    map_go   = 1'b0;
    unique case (state)
      S_CLEAR: st_we = 1'b1;
      S_EXEC:  map_go = !cmd_q && !load_oob;
      S_MAP: begin
        st_we    = map_done && map_res.hit;
        st_waddr = {map_res.row, map_res.col};
        st_wdata = pix_q;
      end
      default: ;
    endcase
  end

  // the next readout pixel and its right neighbor; no write is ever in flight
  // during a read, so no forwarding is needed
  assign st_raddr0 = {read_row, read_col};
  assign st_raddr1 = st_raddr0 + ADDR_W'(1);

  // ---------------- sequencer: registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_col      <= '0;
      load_row      <= '0;
      read_col      <= '0;
      read_row      <= '0;
      readout_phase <= 1'b0;
      filled_left   <= '0;
      clr_addr      <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == S_EXEC) begin
        if (cmd_q) begin
          readout_phase <= 1'b1;
          if (read_oob) begin
            // frame shrank under the read pointer: close the frame
            done          <= 1'b1;
            load_col      <= '0;
            load_row      <= '0;
            read_col      <= '0;
            read_row      <= '0;
            readout_phase <= 1'b0;
            filled_left   <= '0;
          end
        end else if (load_oob) begin
          readout_phase <= 1'b1;
        end
      end
      if (state == S_MAP && map_done) begin
        if (col_inc >= w_cur) begin
          load_col <= '0;
          load_row <= row_inc;
          if (row_inc >= (ROW_W+1)'(h_cur)) begin
            readout_phase <= 1'b1;
          end
        end else begin
          load_col <= col_inc[COL_W-1:0];
        end
      end
      if (state == S_READ) begin
        done        <= 1'b1;
        filled_left <= rd_val;
        if (rd_last) begin
          load_col      <= '0;
          load_row      <= '0;
          read_col      <= '0;
          read_row      <= '0;
          readout_phase <= 1'b0;
          filled_left   <= '0;
        end else if (rcol_inc >= w_cur) begin
          read_col    <= '0;
          read_row    <= rrow_inc[ROW_W-1:0];
          filled_left <= '0;
        end else begin
          read_col <= rcol_inc[COL_W-1:0];
        end
      end
    end
  end

  // command payload and result data
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      pix_q <= pixel_in;
    end
    if (state == S_EXEC) begin
      pixel_out     <= fill_value;
      last_of_frame <= 1'b1;
    end else if (state == S_READ) begin
      pixel_out     <= rd_val;
      last_of_frame <= rd_last;
    end
  end

  irfm_store u_store (
    .clk    (clk),
    .we     (st_we),
    .waddr  (st_waddr),
    .wdata  (st_wdata),
    .raddr0 (st_raddr0),
    .raddr1 (st_raddr1),
    .rdata0 (st_rdata0),
    .rdata1 (st_rdata1)
  );

  irfm_map u_map (
    .clk      (clk),
    .rst      (rst),
    .go       (map_go),
    .col      (load_col),
    .row      (load_row[ROW_W-1:0]),
    .alpha    (alpha),
    .beta     (beta),
    .center_x (center_x),
    .center_y (center_y),
    .width    (w_cur),
    .height   (h_cur),
    .done     (map_done),
    .res      (map_res)
  );

  // ---------------- assertions ----------------
  a_clear_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (st_we && st_wdata == fill_value))
    else $error("clear sweep not writing the fill value");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    st_we |-> (state == S_CLEAR || (state == S_MAP && map_done && map_res.hit)))
    else $error("store write outside clear sweep or mapped load");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_read_ptr_idle: assert property (@(posedge clk) disable iff (rst)
    !readout_phase |-> (read_col == '0 && read_row == '0))
    else $error("read pointer moved while loading");

endmodule

// File: bench/image_rotate_forward_map_test.sv
// ----------------------------------------------------------------------------
// image_rotate_forward_map_test
// Self-checking bench for the forward-mapped rotator: a behavioral copy of the
// frame store predicts every read-out pixel, and each result strobe is compared
// in order against it, under random start gaps and config changes.
// ----------------------------------------------------------------------------
module image_rotate_forward_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irfm_pkg::*;

  // Command codes and the index with no register behind it
  localparam logic                 CMD_LOAD  = 1'b0;
  localparam logic                 CMD_READ  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;

  localparam int unsigned RANDOM_ITEMS  = 800;
  // Margin left after the block goes idle, before touching config
  localparam int unsigned SETTLE_CYCLES = 24;
  // ~10 frames of clear sweep plus item time, taken several times
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  typedef struct {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } pix_result_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  cmd;
  logic [PIXEL_BITS-1:0] pixel_in;
  logic                  done;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  image_rotate_forward_map dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .pixel_in      (pixel_in),
    .done          (done),
    .pixel_out     (pixel_out),
    .last_of_frame (last_of_frame),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Behavioral image of the block: config, counters and the frame store
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] rot_alpha = ALPHA_RESET;
  logic signed [COEF_W-1:0] rot_beta  = '0;
  logic [CTR_W-1:0]         ctr_x     = '0;
  logic [CTR_W-1:0]         ctr_y     = '0;
  logic [PIXEL_BITS-1:0]    fill_px   = '0;
  logic [DIM_W-1:0]         img_w_reg = WIDTH_RESET;
  logic [DIM_W-1:0]         img_h_reg = HEIGHT_RESET;

  logic [PIXEL_BITS-1:0] frame_img [STORE_DEPTH];
  int unsigned load_x = 0, load_y = 0;   // next source pixel
  int unsigned scan_x = 0, scan_y = 0;   // next output pixel
  bit          in_readout = 1'b0;
  int unsigned prev_out = 0;             // left neighbor as already output

  pix_result_t expected_pixels[$];

  int unsigned commands_sent  = 0;
  int unsigned ignored_loads  = 0;
  int unsigned frames_started = 0;
  int unsigned pixels_checked = 0;
  int unsigned errors         = 0;
  int unsigned gap_odds       = 0;       // 0: start never drops between items
  int unsigned cycle_count    = 0;

  // Size registers are clamped into the store's range
  function automatic int unsigned eff_width();
    if (img_w_reg == 0) return 1;
    if (img_w_reg > MAX_WIDTH) return MAX_WIDTH;
    return img_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (img_h_reg == 0) return 1;
    if (img_h_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return img_h_reg;
  endfunction

  // Q.16 to integer, half away from zero
  function automatic longint round_half_away(input longint s);
    if (s >= 0) return (s + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    return -((-s + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W);
  endfunction

  // First command of a frame wipes the store to the fill value
  function automatic void clear_on_frame_start();
    if (!in_readout && load_x == 0 && load_y == 0) begin
      foreach (frame_img[i]) frame_img[i] = fill_px;
      frames_started++;
    end
  endfunction

  function automatic void close_frame();
    load_x = 0;
    load_y = 0;
    scan_x = 0;
    scan_y = 0;
    in_readout = 1'b0;
    prev_out = 0;
  endfunction

  // Advances the model by one command; returns 1 when a pixel comes out
  function automatic bit predict_rotated_pixel(input logic c, input logic [PIXEL_BITS-1:0] px,
                                               output pix_result_t r);
    int unsigned w, h, v;
    longint      dx, dy, nx, ny;
    w = eff_width();
    h = eff_height();
    r.pixel = '0;
    r.last  = 1'b0;
    if (c == CMD_LOAD) begin
      if (in_readout) return 1'b0;
      clear_on_frame_start();
      // position outside a shrunk frame ends loading, pixel dropped
      if (load_x >= w || load_y >= h) begin
        in_readout = 1'b1;
        return 1'b0;
      end
      dx = longint'(load_x) - longint'(ctr_x);
      dy = longint'(load_y) - longint'(ctr_y);
      nx = round_half_away(longint'(rot_alpha) * dx + longint'(rot_beta) * dy) + ctr_x;
      ny = round_half_away(longint'(rot_alpha) * dy - longint'(rot_beta) * dx) + ctr_y;
      if (nx >= 0 && nx < w && ny >= 0 && ny < h)
        frame_img[(ny * MAX_WIDTH + nx) % STORE_DEPTH] = px;
      load_x++;
      if (load_x >= w) begin
        load_x = 0;
        load_y++;
        if (load_y >= h) in_readout = 1'b1;
      end
      return 1'b0;
    end
    // read: an early read ends loading
    if (!in_readout) begin
      clear_on_frame_start();
      in_readout = 1'b1;
    end
    if (scan_x >= w || scan_y >= h) begin
      r.pixel = fill_px;
      r.last  = 1'b1;
      close_frame();
      return 1'b1;
    end
    v = frame_img[scan_y * MAX_WIDTH + scan_x];
    // hole: inner zero next to a lit left neighbor takes the mean with the right
    if (scan_x >= 1 && scan_x + 1 < w && v == 0 && prev_out > 0)
      v = (prev_out + frame_img[scan_y * MAX_WIDTH + scan_x + 1]) / 2;
    prev_out = v;
    r.pixel  = PIXEL_BITS'(v);
    r.last   = (scan_x + 1 == w && scan_y + 1 == h);
    if (r.last) begin
      close_frame();
    end else begin
      scan_x++;
      if (scan_x >= w) begin
        scan_x = 0;
        scan_y++;
        prev_out = 0;
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("image_rotate_forward_map_test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: every strobe pops the oldest expected pixel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    pix_result_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d last_of_frame %0d", pixel_out, last_of_frame);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_out !== want.pixel) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, pixel_out);
          errors++;
        end
        if (last_of_frame !== want.last) begin
          $error("last_of_frame mismatch: expected %0d, actual %0d", want.last, last_of_frame);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One command transaction; start is left high unless a gap follows, so
  // back-to-back commands keep it asserted
  task automatic issue_command(input logic c, input logic [PIXEL_BITS-1:0] px);
    pix_result_t r;
    bit          skipped;
    @(negedge clk);
    start    <= 1'b1;
    cmd      <= c;
    pixel_in <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    skipped = (c == CMD_LOAD) && in_readout;
    if (predict_rotated_pixel(c, px, r)) expected_pixels.push_back(r);
    if (skipped) ignored_loads++;
    else commands_sent++;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  endtask

  // Quiesce: no result pending, busy low, then a settle margin
  task automatic drain_and_idle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Config write transaction; the model picks up the register on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ALPHA:    rot_alpha = data;
      REG_BETA:     rot_beta  = data;
      REG_CENTER_X: ctr_x     = data[CTR_W-1:0];
      REG_CENTER_Y: ctr_y     = data[CTR_W-1:0];
      REG_FILL:     fill_px   = data[PIXEL_BITS-1:0];
      REG_WIDTH:    img_w_reg = data[DIM_W-1:0];
      REG_HEIGHT:   img_h_reg = data[DIM_W-1:0];
      default:      ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Junk above a narrow register's field half the time
  function automatic logic [CFG_DATA_W-1:0] pad_high(input int unsigned value,
                                                     input int unsigned bits);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(value);
    if ($urandom_range(0, 1))
      for (int i = bits; i < CFG_DATA_W; i++) d[i] = $urandom_range(0, 1);
    return d;
  endfunction

  // Zeros are frequent so holes show up
  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return '1;
      default: return PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef_extreme();
    case ($urandom_range(0, 3))
      0:       return 20'h80000;   // -8.0
      1:       return 20'h7FFFF;   // just under +8.0
      2:       return 20'h00000;
      default: return 20'h10000;   // 1.0
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset config (identity, 256x256, fill 0). A read before the frame is
  // fully loaded ends loading; the middle zero is filled from its neighbors.
  // Shrinking the width under the read position then closes the frame.
  task automatic test_defaults_early_read();
    issue_command(CMD_LOAD, 8'd255);
    issue_command(CMD_LOAD, 8'd0);
    issue_command(CMD_LOAD, 8'd100);
    repeat (3) issue_command(CMD_READ, 8'hA5);
    drain_and_idle();
    write_reg(REG_WIDTH, 20'd3);
    issue_command(CMD_READ, 8'h5A);
  endtask

  // 3x2 frame at half scale around column 2: both halves round away from
  // zero, two source pixels land on one target (last one wins), column 0
  // keeps the fill and the overwritten zero becomes a hole to fill.
  // A load after the frame is complete must be ignored.
  task automatic test_half_scale_overwrite();
    drain_and_idle();
    write_reg(REG_ALPHA,    20'h08000);
    write_reg(REG_BETA,     20'h00000);
    write_reg(REG_CENTER_X, 20'd2);
    write_reg(REG_CENTER_Y, 20'd0);
    write_reg(REG_FILL,     20'h80);
    write_reg(REG_WIDTH,    20'd3);
    write_reg(REG_HEIGHT,   20'd2);
    write_reg(REG_NONE,     20'hFFFFF);
    issue_command(CMD_LOAD, 8'd50);
    issue_command(CMD_LOAD, 8'd0);
    issue_command(CMD_LOAD, 8'd90);
    issue_command(CMD_LOAD, 8'd255);
    issue_command(CMD_LOAD, 8'd0);
    issue_command(CMD_LOAD, 8'd1);
    issue_command(CMD_LOAD, 8'd77);
    do issue_command(CMD_READ, 8'h00); while (in_readout);
  endtask

  // Out-of-range sizes clamp (511 -> 256, 0 -> 1); extreme coefficients and
  // centers throw targets off the frame. A width cut below the load position
  // ends loading on the next load, and the lone pixel is the last one.
  task automatic test_clamp_and_load_shrink();
    drain_and_idle();
    write_reg(REG_ALPHA,    20'h80000);
    write_reg(REG_BETA,     20'h7FFFF);
    write_reg(REG_CENTER_X, 20'd255);
    write_reg(REG_CENTER_Y, 20'd255);
    write_reg(REG_FILL,     20'hFF);
    write_reg(REG_WIDTH,    20'd511);
    write_reg(REG_HEIGHT,   20'd0);
    issue_command(CMD_LOAD, 8'h55);
    issue_command(CMD_LOAD, 8'hAA);
    drain_and_idle();
    write_reg(REG_WIDTH, 20'd1);
    issue_command(CMD_LOAD, 8'hC3);
    issue_command(CMD_READ, 8'h3C);
  endtask

  // One random frame: fresh geometry, coefficients, center and fill; mostly a
  // full load followed by a full readout, sometimes cut short by an early
  // read and/or a size cut in the middle of loading or readout.
  task automatic run_random_frame(input bit quiet);
    int unsigned ew, eh, pixels, n_load, n_read, remaining;
    bit          broken;
    real         ang, zoom;
    drain_and_idle();
    gap_odds = quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : 2 << $urandom_range(0, 2));

    if ($urandom_range(0, 9) == 0) begin
      // whole field range, clamps included; such frames are usually huge
      write_reg(REG_WIDTH,  pad_high($urandom_range(0, 511), DIM_W));
      write_reg(REG_HEIGHT, pad_high($urandom_range(0, 511), DIM_W));
    end else begin
      write_reg(REG_WIDTH,  pad_high($urandom_range(1, 24), DIM_W));
      write_reg(REG_HEIGHT, pad_high($urandom_range(1, 12), DIM_W));
    end
    ew = eff_width();
    eh = eff_height();

    case ($urandom_range(0, 9))
      7: begin
        write_reg(REG_ALPHA, CFG_DATA_W'($urandom));
        write_reg(REG_BETA,  CFG_DATA_W'($urandom));
      end
      8: begin
        write_reg(REG_ALPHA, rand_coef_extreme());
        write_reg(REG_BETA,  rand_coef_extreme());
      end
      default: begin
        // rotation by a whole degree, scaled 0.5 .. 2.0
        ang  = real'($urandom_range(0, 359)) * 3.141592653589793 / 180.0;
        zoom = 0.5 + real'($urandom_range(0, 150)) / 100.0;
        write_reg(REG_ALPHA, CFG_DATA_W'($rtoi($cos(ang) * zoom * 65536.0)));
        write_reg(REG_BETA,  CFG_DATA_W'($rtoi($sin(ang) * zoom * 65536.0)));
      end
    endcase

    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_CENTER_X, pad_high($urandom_range(0, 255), CTR_W));
      write_reg(REG_CENTER_Y, pad_high($urandom_range(0, 255), CTR_W));
    end else begin
      write_reg(REG_CENTER_X, pad_high($urandom_range(0, ew - 1), CTR_W));
      write_reg(REG_CENTER_Y, pad_high($urandom_range(0, eh - 1), CTR_W));
    end
    write_reg(REG_FILL, pad_high($urandom_range(0, 1) ? 0 : $urandom_range(0, 255), PIXEL_BITS));

    pixels = ew * eh;
    broken = (pixels > 400) || ($urandom_range(0, 3) == 0);
    n_load = broken ? $urandom_range(0, (pixels - 1 < 40) ? pixels - 1 : 40) : pixels;
    repeat (n_load) issue_command(CMD_LOAD, rand_pixel());

    if (broken && load_x > 0 && $urandom_range(0, 1)) begin
      // cut the width under the load position; next load ends loading
      drain_and_idle();
      write_reg(REG_WIDTH, CFG_DATA_W'(load_x));
      issue_command(CMD_LOAD, rand_pixel());
    end else if (!broken) begin
      repeat ($urandom_range(0, 2)) issue_command(CMD_LOAD, rand_pixel());
    end

    remaining = eff_width() * eff_height() - (scan_y * eff_width() + scan_x);
    if (broken && remaining >= 2 && (remaining > 400 || $urandom_range(0, 1))) begin
      n_read = $urandom_range(1, (remaining - 1 < 40) ? remaining - 1 : 40);
      repeat (n_read) issue_command(CMD_READ, rand_pixel());
      // cut the size under the read position; next read returns the fill
      drain_and_idle();
      if (scan_x > 0) write_reg(REG_WIDTH, CFG_DATA_W'(scan_x));
      else write_reg(REG_HEIGHT, CFG_DATA_W'(scan_y));
      issue_command(CMD_READ, rand_pixel());
    end else begin
      do issue_command(CMD_READ, rand_pixel()); while (in_readout);
    end
  endtask

  task automatic test_random_frames();
    int unsigned base;
    base = commands_sent;
    while (commands_sent - base < RANDOM_ITEMS)
      run_random_frame(commands_sent - base >= RANDOM_ITEMS * 4 / 5);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_LOAD;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    gap_odds = 3;
    test_defaults_early_read();
    test_half_scale_overwrite();
    test_clamp_and_load_shrink();
    test_random_frames();
    drain_and_idle();

    $display("Ran %0d commands over %0d frames (%0d loads dropped in readout); %0d pixels checked",
             commands_sent, frames_started, ignored_loads, pixels_checked);
    $display("Mismatches or stray results: %0d", errors);
    if (errors == 0) $display("image_rotate_forward_map_test passed");
    else $display("image_rotate_forward_map_test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/irfm_pkg.sv
hw/rtl/irfm_store.sv
hw/rtl/irfm_map.sv
hw/rtl/image_rotate_forward_map.sv
bench/image_rotate_forward_map_test.sv
